/* hw/rtl/mtb_pkg.sv */
// ----------------------------------------------------------------------------
// mtb_pkg
// Shared types and constants for the MAC address text parser.
// ----------------------------------------------------------------------------
package mtb_pkg;

	// Parse limits
	localparam int MAX_CHARS  = 17;  // characters examined per string, 12..31
	localparam int ADDR_BYTES = 6;   // address bytes, 1..8

	// State widths fixed by the text format
	localparam int POS_W   = 5;
	localparam int DIGIT_W = 4;
	localparam int NIB_W   = 4;

	// Queue between front and back; depth must be a power of two
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// ASCII codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF_HEX = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] HEX_TEN  = 8'd10;

	// Character class decided by the front end
	typedef enum logic [1:0] {
		KIND_DIGIT = 2'd0,
		KIND_SEP   = 2'd1,
		KIND_NUL   = 2'd2,
		KIND_BAD   = 2'd3
	} kind_t;

	// Input beat
	typedef struct packed {
		logic [7:0] char_in;
		logic       first_char;
	} char_beat_t;

	// Result beat
	typedef struct packed {
		logic       byte_valid;
		logic [2:0] byte_index;
		logic [7:0] byte_value;
		logic       finished;
		logic       status;
		logic       ignored;
	} result_beat_t;

	// Classified character passed from front to back
	typedef struct packed {
		logic             first;
		kind_t            kind;
		logic [NIB_W-1:0] nib;
	} cls_t;

	// Queue status seen by the top level
	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic              full;
		logic              empty;
	} q_status_t;

endpackage

/* hw/rtl/mtb_classify.sv */
// ----------------------------------------------------------------------------
// mtb_classify
// Front end: accepts characters and registers their class and nibble.
// ----------------------------------------------------------------------------
module mtb_classify (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                char_valid,
	output logic                char_stall,
	input  mtb_pkg::char_beat_t char_beat,
	output logic                cls_valid,
	input  logic                cls_stall,
	output mtb_pkg::cls_t       cls
);

	mtb_pkg::cls_t cls_d;
	mtb_pkg::cls_t cls_s1;
	logic          valid_s1;
	logic [7:0]    c;
	logic          take;

	assign c = char_beat.char_in;

	// Decode one character
	always_comb begin
		cls_d.first = char_beat.first_char;
		cls_d.nib   = '0;
		if (c >= mtb_pkg::CH_0 && c <= mtb_pkg::CH_9) begin
			cls_d.kind = mtb_pkg::KIND_DIGIT;
			cls_d.nib  = mtb_pkg::NIB_W'(c - mtb_pkg::CH_0);
		end else if (c >= mtb_pkg::CH_LA && c <= mtb_pkg::CH_LF_HEX) begin
			cls_d.kind = mtb_pkg::KIND_DIGIT;
			cls_d.nib  = mtb_pkg::NIB_W'(c - mtb_pkg::CH_LA + mtb_pkg::HEX_TEN);
		end else if (c >= mtb_pkg::CH_UA && c <= mtb_pkg::CH_UF) begin
			cls_d.kind = mtb_pkg::KIND_DIGIT;
			cls_d.nib  = mtb_pkg::NIB_W'(c - mtb_pkg::CH_UA + mtb_pkg::HEX_TEN);
		end else if (c == mtb_pkg::CH_COLON || c == mtb_pkg::CH_DASH ||
				c == mtb_pkg::CH_COMMA || c == mtb_pkg::CH_CR ||
				c == mtb_pkg::CH_LF) begin
			cls_d.kind = mtb_pkg::KIND_SEP;
		end else if (c == mtb_pkg::CH_NUL) begin
			cls_d.kind = mtb_pkg::KIND_NUL;
		end else begin
			cls_d.kind = mtb_pkg::KIND_BAD;
		end
	end

	// Stage register: holds while the queue is full
	assign char_stall = valid_s1 && cls_stall;
	assign take       = char_valid && !char_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!char_stall) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cls_s1 <= cls_d;
		end
	end

	assign cls_valid = valid_s1;
	assign cls       = cls_s1;

endmodule

/* hw/rtl/mtb_queue.sv */
// ----------------------------------------------------------------------------
// mtb_queue
// Short FIFO of classified characters between front and back end.
// ----------------------------------------------------------------------------
module mtb_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_valid,
	output logic                 wr_stall,
	input  mtb_pkg::cls_t        wr_data,
	output logic                 rd_valid,
	input  logic                 rd_stall,
	output mtb_pkg::cls_t        rd_data,
	output mtb_pkg::q_status_t   status
);

	mtb_pkg::cls_t                   mem_q [mtb_pkg::QDEPTH];
	logic [mtb_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [mtb_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [mtb_pkg::QCNT_W-1:0]      count_q;
	logic                            push;
	logic                            pop;

	assign status.count = count_q;
	assign status.full  = (count_q == mtb_pkg::QCNT_W'(mtb_pkg::QDEPTH));
	assign status.empty = (count_q == '0);

	assign wr_stall = status.full;
	assign rd_valid = !status.empty;
	assign rd_data  = mem_q[rd_ptr_q];

	assign push = wr_valid && !wr_stall;
	assign pop  = rd_valid && !rd_stall;

	// Pointers and fill count; pointers wrap since depth is a power of two
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

/* hw/rtl/mtb_exec.sv */
// ----------------------------------------------------------------------------
// mtb_exec
// Back end: holds parse state, builds bytes and registers one result beat.
// ----------------------------------------------------------------------------
module mtb_exec (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cls_valid,
	output logic                  cls_stall,
	input  mtb_pkg::cls_t         cls,
	output logic                  result_valid,
	input  logic                  result_stall,
	output mtb_pkg::result_beat_t result_beat
);

	logic [mtb_pkg::POS_W-1:0]   pos_q;
	logic [mtb_pkg::DIGIT_W-1:0] digits_q;
	logic [mtb_pkg::NIB_W-1:0]   high_q;
	logic                        done_q;
	logic                        out_valid_q;
	mtb_pkg::result_beat_t       out_q;

	logic [mtb_pkg::POS_W-1:0]   pos_cur, pos_n;
	logic [mtb_pkg::DIGIT_W-1:0] digits_cur, digits_n;
	logic [mtb_pkg::DIGIT_W:0]   digits_inc;
	logic [mtb_pkg::NIB_W-1:0]   high_cur, high_n;
	logic                        done_cur, done_n;
	logic [mtb_pkg::POS_W-1:0]   pos_inc;
	mtb_pkg::result_beat_t       res;
	logic                        take;

	// Output register frees itself when the receiver takes the beat
	assign cls_stall = out_valid_q && result_stall;
	assign take      = cls_valid && !cls_stall;

	// A first character starts from the cleared state
	assign pos_cur    = cls.first ? '0 : pos_q;
	assign digits_cur = cls.first ? '0 : digits_q;
	assign high_cur   = cls.first ? '0 : high_q;
	assign done_cur   = cls.first ? 1'b0 : done_q;

	assign digits_inc = {1'b0, digits_cur} + 1'b1;
	assign pos_inc    = pos_cur + 1'b1;

	// Next state and result
	always_comb begin
		res      = '0;
		pos_n    = pos_cur;
		digits_n = digits_cur;
		high_n   = high_cur;
		done_n   = done_cur;
		if (done_cur) begin
			res.ignored = 1'b1;
		end else begin
			case (cls.kind) inside
				mtb_pkg::KIND_DIGIT, mtb_pkg::KIND_SEP: begin
					if (cls.kind == mtb_pkg::KIND_DIGIT) begin
						res.byte_valid = 1'b1;
						res.byte_index = digits_cur[3:1];
						if (!digits_cur[0]) begin
							high_n         = cls.nib;
							res.byte_value = {cls.nib, 4'h0};
						end else begin
							res.byte_value = {high_cur, cls.nib};
						end
						digits_n = digits_inc[mtb_pkg::DIGIT_W-1:0];
						if (digits_inc[mtb_pkg::DIGIT_W:1] >=
								mtb_pkg::DIGIT_W'(mtb_pkg::ADDR_BYTES)) begin
							res.finished = 1'b1;
							done_n       = 1'b1;
						end
					end
					pos_n = pos_inc;
					if (pos_inc >= mtb_pkg::POS_W'(mtb_pkg::MAX_CHARS)) begin
						res.finished = 1'b1;
						done_n       = 1'b1;
					end
				end
				mtb_pkg::KIND_NUL: begin
					res.finished = 1'b1;
					done_n       = 1'b1;
				end
				default: begin
					res.finished = 1'b1;
					res.status   = 1'b1;
					done_n       = 1'b1;
				end
			endcase
		end
	end

	// Parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			digits_q <= '0;
			high_q   <= '0;
			done_q   <= 1'b0;
		end else if (take) begin
			pos_q    <= pos_n;
			digits_q <= digits_n;
			high_q   <= high_n;
			done_q   <= done_n;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!cls_stall) begin
			out_valid_q <= cls_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= res;
		end
	end

	assign result_valid = out_valid_q;
	assign result_beat  = out_q;

endmodule

/* hw/rtl/mac_text_to_bytes_parser.sv */
// ----------------------------------------------------------------------------
// mac_text_to_bytes_parser
// Parses a textual MAC address one character per beat into address bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Characters enter on char_valid / char_stall / char_beat; set first_char
//   on the first character of each string. Every character gives exactly one
//   beat on result_valid / result_stall / result_beat: hex digits report the
//   byte they wrote, separators report no byte, NUL, a bad character or a
//   parse limit ends the string, and characters after the end come back with
//   ignored set. Each character passes the classify register, a queue entry
//   and the result register before its beat shows on result_valid.
//   Throughput: one character per cycle while nothing stalls, set by the
//   parse state update in the back end. The two-entry queue lets the front
//   keep taking characters for a short while when the receiver stalls; once
//   it and the front register fill, char_stall rises. Reset clears the parse
//   state to that of a fresh string and empties all pipeline stages.
// ----------------------------------------------------------------------------
module mac_text_to_bytes_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  char_valid,
	output logic                  char_stall,
	input  mtb_pkg::char_beat_t   char_beat,
	output logic                  result_valid,
	input  logic                  result_stall,
	output mtb_pkg::result_beat_t result_beat
);

	logic               front_valid;
	logic               front_stall;
	mtb_pkg::cls_t      front_cls;
	logic               back_valid;
	logic               back_stall;
	mtb_pkg::cls_t      back_cls;
	mtb_pkg::q_status_t q_status;

	// Front end
	mtb_classify u_classify (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_beat  (char_beat),
		.cls_valid  (front_valid),
		.cls_stall  (front_stall),
		.cls        (front_cls)
	);

	// Decoupling queue
	mtb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (front_valid),
		.wr_stall (front_stall),
		.wr_data  (front_cls),
		.rd_valid (back_valid),
		.rd_stall (back_stall),
		.rd_data  (back_cls),
		.status   (q_status)
	);

	// Back end
	mtb_exec u_exec (
		.clk          (clk),
		.arst_n       (arst_n),
		.cls_valid    (back_valid),
		.cls_stall    (back_stall),
		.cls          (back_cls),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_beat  (result_beat)
	);

	// Checks
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_status.count <= mtb_pkg::QCNT_W'(mtb_pkg::QDEPTH))
		else $error("queue count above depth");

	a_ignored_alone: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_beat.ignored |->
		!result_beat.byte_valid && !result_beat.finished)
		else $error("ignored beat carries data");

	a_status_finished: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_beat.status |-> result_beat.finished)
		else $error("error status without finish");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_beat.byte_valid |->
		result_beat.byte_index < 3'(mtb_pkg::ADDR_BYTES))
		else $error("byte index out of range");

	a_front_stall: assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |-> q_status.full)
		else $error("front stalls with room in queue");

endmodule

/* verif/tb_mac_text_to_bytes_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mac_text_to_bytes_parser
// Self-checking bench for the MAC address text parser. A driver feeds
// character beats from a queue and a monitor checks every result beat
// against a cycle-free predictor of the parse state. Directed strings cover
// the digit cases, the separators, NUL, bad and top-bit characters, the
// char-after-end rule and both parse limits. Random traffic is mostly
// well-formed addresses with noise and broken strings mixed in. Both sides
// throttle at random, apart from one quiet stretch.
// ----------------------------------------------------------------------------
module tb_mac_text_to_bytes_parser;

	localparam int   N_CHARS   = 1600;
	localparam int   CYC_LIMIT = 200000;
	localparam int   IDLE_PCT  = 28;
	localparam logic STAT_OK   = 1'b0;
	localparam logic STAT_BAD  = 1'b1;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  char_valid;
	logic                  char_stall;
	mtb_pkg::char_beat_t   char_beat;
	logic                  result_valid;
	logic                  result_stall;
	mtb_pkg::result_beat_t result_beat;

	// stimulus and expected-result stores
	mtb_pkg::char_beat_t   char_q [$];
	mtb_pkg::result_beat_t parse_q [$];

	// predicted parse state
	logic [4:0] pos_cnt;
	logic [3:0] dig_cnt;
	logic [3:0] hi_nib;
	logic       str_done;

	int   n_items;
	int   n_taken;
	int   n_results;
	int   n_errs;
	int   cyc;
	logic char_taken;
	wire  calm = (cyc >= 1200) && (cyc < 2000);

	mac_text_to_bytes_parser dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.char_beat    (char_beat),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_beat  (result_beat)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// -1 when c is not a hex digit
	function automatic int char_nib(logic [7:0] c);
		if (c >= mtb_pkg::CH_0 && c <= mtb_pkg::CH_9)
			return int'(c - mtb_pkg::CH_0);
		if (c >= mtb_pkg::CH_LA && c <= mtb_pkg::CH_LF_HEX)
			return int'(c - mtb_pkg::CH_LA + mtb_pkg::HEX_TEN);
		if (c >= mtb_pkg::CH_UA && c <= mtb_pkg::CH_UF)
			return int'(c - mtb_pkg::CH_UA + mtb_pkg::HEX_TEN);
		return -1;
	endfunction

	function automatic logic is_sep(logic [7:0] c);
		return c == mtb_pkg::CH_COLON || c == mtb_pkg::CH_DASH ||
			c == mtb_pkg::CH_COMMA || c == mtb_pkg::CH_CR || c == mtb_pkg::CH_LF;
	endfunction

	function automatic logic [7:0] pick_sep();
		case ($urandom_range(4))
			0: return mtb_pkg::CH_COLON;
			1: return mtb_pkg::CH_DASH;
			2: return mtb_pkg::CH_COMMA;
			3: return mtb_pkg::CH_CR;
			default: return mtb_pkg::CH_LF;
		endcase
	endfunction

	// hex digit in random case
	function automatic logic [7:0] hex_char(logic [3:0] n);
		if (n < 10)
			return mtb_pkg::CH_0 + n;
		if ($urandom_range(1))
			return mtb_pkg::CH_LA + n - mtb_pkg::HEX_TEN;
		return mtb_pkg::CH_UA + n - mtb_pkg::HEX_TEN;
	endfunction

	// advance the parse state by one character, give its result beat
	function automatic mtb_pkg::result_beat_t parse_char(mtb_pkg::char_beat_t b);
		mtb_pkg::result_beat_t r;
		int                    nib;
		logic [4:0]            dnext;
		r = '0;
		if (b.first_char) begin
			pos_cnt  = '0;
			dig_cnt  = '0;
			hi_nib   = '0;
			str_done = 1'b0;
		end
		if (str_done) begin
			r.ignored = 1'b1;
		end else begin
			nib = char_nib(b.char_in);
			if (nib >= 0 || is_sep(b.char_in)) begin
				if (nib >= 0) begin
					r.byte_valid = 1'b1;
					r.byte_index = dig_cnt[3:1];
					if (!dig_cnt[0]) begin
						hi_nib       = nib[3:0];
						r.byte_value = {nib[3:0], 4'h0};
					end else begin
						r.byte_value = {hi_nib, nib[3:0]};
					end
					dnext   = {1'b0, dig_cnt} + 5'd1;
					dig_cnt = dnext[3:0];
					if (dnext[4:1] >= mtb_pkg::ADDR_BYTES) begin
						r.finished = 1'b1;
						str_done   = 1'b1;
					end
				end
				// digits and separators both count toward the char limit
				pos_cnt = pos_cnt + 5'd1;
				if (pos_cnt >= mtb_pkg::MAX_CHARS) begin
					r.finished = 1'b1;
					str_done   = 1'b1;
				end
			end else if (b.char_in == mtb_pkg::CH_NUL) begin
				r.finished = 1'b1;
				r.status   = STAT_OK;
				str_done   = 1'b1;
			end else begin
				r.finished = 1'b1;
				r.status   = STAT_BAD;
				str_done   = 1'b1;
			end
		end
		return r;
	endfunction

	task automatic report(string msg);
		$display("ERROR @%0d: %s", cyc, msg);
		n_errs++;
	endtask

	task automatic cmp_field(string name, logic [7:0] got, logic [7:0] want);
		if (got !== want)
			report($sformatf("result %0d: %s got %0h want %0h", n_results, name, got, want));
	endtask

	task automatic push_char(logic [7:0] c, logic f);
		mtb_pkg::char_beat_t b;
		b.char_in    = c;
		b.first_char = f;
		char_q.push_back(b);
	endtask

	// driver: new beat at the falling edge once the last one was taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (!char_valid || char_taken) begin
				if (!calm && $urandom_range(99) < IDLE_PCT) begin
					char_valid <= 1'b0;
				end else if (char_q.size() != 0) begin
					char_beat  <= char_q.pop_front();
					char_valid <= 1'b1;
				end else begin
					char_valid <= 1'b0;
				end
			end
			result_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
		end
	end

	// monitor: check result beats, predict on accepted character beats
	always @(posedge clk) begin : mon
		mtb_pkg::result_beat_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				n_results++;
				if (parse_q.size() == 0) begin
					report($sformatf("result %0d with nothing expected", n_results));
				end else begin
					want = parse_q.pop_front();
					cmp_field("byte_valid", 8'(result_beat.byte_valid),
						8'(want.byte_valid));
					cmp_field("byte_index", 8'(result_beat.byte_index),
						8'(want.byte_index));
					cmp_field("byte_value", result_beat.byte_value, want.byte_value);
					cmp_field("finished", 8'(result_beat.finished), 8'(want.finished));
					cmp_field("status", 8'(result_beat.status), 8'(want.status));
					cmp_field("ignored", 8'(result_beat.ignored), 8'(want.ignored));
				end
			end
			if (char_valid && !char_stall) begin
				parse_q.push_back(parse_char(char_beat));
				n_taken++;
			end
			char_taken <= char_valid && !char_stall;
		end
	end

	// run limit
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > CYC_LIMIT) begin
			$display("** mac_text_to_bytes_parser: FAILED **");
			$finish;
		end
	end

	initial begin
		logic [17*8-1:0] full_mac;
		logic [7:0]      s [$];
		logic [7:0]      c;
		int              counted;
		int              nbytes;
		int              sep_mode;
		int              len;
		logic [7:0]      sep;
		logic            lead;

		arst_n       = 1'b0;
		char_valid   = 1'b0;
		char_beat    = '0;
		result_stall = 1'b0;
		char_taken   = 1'b0;
		pos_cnt      = '0;
		dig_cnt      = '0;
		hi_nib       = '0;
		str_done     = 1'b0;
		n_taken      = 0;
		n_results    = 0;
		n_errs       = 0;
		cyc          = 0;

		// directed: parse straight out of reset, NUL end, char after end
		push_char("F", 1'b0);
		push_char("f", 1'b0);
		push_char(mtb_pkg::CH_NUL, 1'b0);
		push_char("Z", 1'b0);
		// top-bit characters: error end, then ignored
		push_char("9", 1'b1);
		push_char(8'hFF, 1'b0);
		push_char(8'h80, 1'b0);
		// 12 digits and 5 separators: last digit hits both limits at once
		full_mac = {"aB:cD-Ef,09", mtb_pkg::CH_CR, "A3", mtb_pkg::CH_LF, "45"};
		for (int i = 0; i < 17; i++)
			push_char(full_mac[8*(16-i) +: 8], i == 0);
		push_char("G", 1'b0);

		// random strings, mostly well-formed
		counted = 0;
		while (counted < N_CHARS) begin
			s.delete();
			if ($urandom_range(99) < 75) begin
				sep_mode = $urandom_range(3);
				sep      = pick_sep();
				nbytes   = ($urandom_range(3) == 0) ? $urandom_range(1, 6) : 6;
				for (int b = 0; b < nbytes; b++) begin
					if (b > 0) begin
						case (sep_mode)
							1: s.push_back(sep);
							2: s.push_back(pick_sep());
							3: begin
								// doubled separators run into the char limit
								s.push_back(pick_sep());
								s.push_back(pick_sep());
							end
							default: ;
						endcase
					end
					s.push_back(hex_char(4'($urandom_range(15))));
					s.push_back(hex_char(4'($urandom_range(15))));
				end
				if ($urandom_range(9) == 0)
					void'(s.pop_back());
				if (nbytes < 6 && $urandom_range(1))
					s.push_back(mtb_pkg::CH_NUL);
				// broken string: a bad character somewhere
				if ($urandom_range(9) == 0) begin
					do
						c = 8'($urandom_range(255));
					while (char_nib(c) >= 0 || is_sep(c) || c == mtb_pkg::CH_NUL);
					s[$urandom_range(s.size() - 1)] = c;
				end
				lead = ($urandom_range(9) != 0);
				foreach (s[i])
					push_char(s[i], (i == 0) ? lead : 1'b0);
				counted += s.size();
			end else begin
				// noise
				len = $urandom_range(1, 20);
				for (int i = 0; i < len; i++)
					push_char(8'($urandom_range(255)),
						(i == 0) ? 1'($urandom_range(1)) : ($urandom_range(15) == 0));
				counted += len;
			end
			// trailing junk after the string
			len = $urandom_range(2);
			for (int i = 0; i < len; i++)
				push_char(8'($urandom_range(255)), 1'b0);
			counted += len;
		end
		n_items = char_q.size();

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (n_taken != n_items)
			@(posedge clk);
		while (parse_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (n_errs == 0)
			$display("** mac_text_to_bytes_parser: PASSED **");
		else
			$display("** mac_text_to_bytes_parser: FAILED **");
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/mtb_pkg.sv
hw/rtl/mtb_classify.sv
hw/rtl/mtb_queue.sv
hw/rtl/mtb_exec.sv
hw/rtl/mac_text_to_bytes_parser.sv
verif/tb_mac_text_to_bytes_parser.sv
